[sv/bffa_pkg.sv]
package bffa_pkg;

	// default heap geometry
	localparam int HEAP_LOG2_DEF      = 16;
	localparam int RESERVED_BYTES_DEF = 256;

	// width of unit counts (a 17-bit byte size rounds up to at most 8192 units)
	localparam int NEED_W = 14;

	// pairs handled by the chunk unit in one cycle
	localparam int CHUNK_PAIRS = 8;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	// bitmap pair codes
	localparam logic [1:0] PAIR_FREE  = 2'b11;
	localparam logic [1:0] PAIR_START = 2'b01;
	localparam logic [1:0] PAIR_CONT  = 2'b00;

	// what the chunk unit does with the current eight pairs
	typedef enum logic [1:0] {
		MODE_SCAN,
		MODE_MARK,
		MODE_FREE
	} mode_t;

	// chunk unit result
	typedef struct packed {
		logic [2*CHUNK_PAIRS-1:0] pairs;
		logic [NEED_W-1:0]        run;
		logic [NEED_W-1:0]        cnt;
		logic                     hit;
		logic [2:0]               pos;
	} chunk_res_t;

endpackage

[sv/bffa_ram.sv]
module bffa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/bffa_chunk.sv]
module bffa_chunk (
	input  bffa_pkg::mode_t                          mode,
	input  logic [2*bffa_pkg::CHUNK_PAIRS-1:0]       pairs_in,
	input  logic [2:0]                               off,
	input  logic                                     first,
	input  logic [bffa_pkg::NEED_W-1:0]              run_in,
	input  logic [bffa_pkg::NEED_W-1:0]              need,
	input  logic [bffa_pkg::NEED_W-1:0]              cnt_in,
	output bffa_pkg::chunk_res_t                     res
);

	logic [1:0]                         pair_v;
	logic [bffa_pkg::NEED_W-1:0]        run_v;
	logic [2*bffa_pkg::CHUNK_PAIRS-1:0] pairs_v;
	logic                               hit_v;
	logic                               stop_v;
	logic [2:0]                         pos_v;
	logic [3:0]                         span;

	// pairs from off to the end of the chunk
	assign span = 4'(bffa_pkg::CHUNK_PAIRS) - {1'b0, off};

	// walk the eight pairs, unit with lowest index in the high bits
	always_comb begin
		run_v   = run_in;
		pairs_v = pairs_in;
		hit_v   = 1'b0;
		stop_v  = 1'b0;
		pos_v   = 3'd0;
		pair_v  = 2'b00;
		for (int k = 0; k < bffa_pkg::CHUNK_PAIRS; k++) begin
			pair_v = pairs_in[2*bffa_pkg::CHUNK_PAIRS-2-2*k +: 2];
			case (mode)
				bffa_pkg::MODE_SCAN: begin
					if (!hit_v) begin
						if (pair_v == bffa_pkg::PAIR_FREE) begin
							run_v = run_v + 1'b1;
						end else begin
							run_v = '0;
						end
						if (run_v >= need) begin
							hit_v = 1'b1;
							pos_v = 3'(k);
						end
					end
				end
				bffa_pkg::MODE_MARK: begin
					if (3'(k) >= off &&
					    bffa_pkg::NEED_W'(3'(k) - off) < cnt_in) begin
						pairs_v[2*bffa_pkg::CHUNK_PAIRS-2-2*k +: 2] =
							(first && 3'(k) == off) ? bffa_pkg::PAIR_START
							                        : bffa_pkg::PAIR_CONT;
					end
				end
				bffa_pkg::MODE_FREE: begin
					if (3'(k) >= off && !stop_v) begin
						if (first && 3'(k) == off) begin
							pairs_v[2*bffa_pkg::CHUNK_PAIRS-2-2*k +: 2] = bffa_pkg::PAIR_FREE;
						end else if (pair_v == bffa_pkg::PAIR_FREE ||
						             pair_v == bffa_pkg::PAIR_START) begin
							stop_v = 1'b1;
							hit_v  = 1'b1;
						end else begin
							pairs_v[2*bffa_pkg::CHUNK_PAIRS-2-2*k +: 2] = bffa_pkg::PAIR_FREE;
						end
					end
				end
				default: begin
					pairs_v = pairs_in;
				end
			endcase
		end
	end

	// marking ends in this chunk once the remaining count fits
	always_comb begin
		res       = '0;
		res.pairs = pairs_v;
		res.run   = run_v;
		res.pos   = pos_v;
		res.cnt   = cnt_in;
		res.hit   = hit_v;
		if (mode == bffa_pkg::MODE_MARK) begin
			if (cnt_in <= bffa_pkg::NEED_W'(span)) begin
				res.hit = 1'b1;
				res.cnt = '0;
			end else begin
				res.hit = 1'b0;
				res.cnt = cnt_in - bffa_pkg::NEED_W'(span);
			end
		end
	end

endmodule

[sv/bitmap_first_fit_allocator_core.sv]
// First-fit allocator over a heap of 2^HEAP_LOG2 bytes kept as a bitmap of 16-byte units
// (two bits a unit: 11 free, 01 block start, 00 continuation) in a RAM of 64-bit words.
// After reset a clearing pass writes the initial bitmap, one word a cycle; the
// bitmap's own units and the reserved area come up allocated, and no request is
// taken until the pass is done. One request is worked at a time: a shared chunk unit
// handles eight pairs a cycle, four chunks to a full bitmap word. An allocate scans
// from unit 0 chunk by chunk and then marks the found run in each eight-unit chunk it
// touches; a free walks the chunks from the freed unit until it meets a free unit, a
// block start or the end of the heap. Refused requests go straight from idle to the
// response state. A result is held in an output register, so the next request can
// start while it waits to be taken.
module bitmap_first_fit_allocator_core #(
	parameter int HEAP_LOG2      = bffa_pkg::HEAP_LOG2_DEF,
	parameter int RESERVED_BYTES = bffa_pkg::RESERVED_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // size_bytes[16:0], block_offset[32:17], zero pad
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // status[1:0], alloc_offset[17:2], frag_total[49:18], pad
);

	localparam int UW        = HEAP_LOG2 - 4;
	localparam int WW        = HEAP_LOG2 - 9;
	localparam int MAP_WORDS = 1 << WW;
	localparam int MAP_UNITS = 1 << (HEAP_LOG2 - 10);
	localparam int RES_UNITS = (RESERVED_BYTES + 15) / 16;
	localparam int NW        = bffa_pkg::NEED_W;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_WORK,
		S_RESP
	} state_t;

	state_t                  state_q;
	bffa_pkg::mode_t         mode_q;
	logic [WW-1:0]           clr_q;
	logic [UW-1:0]           cur_q;
	logic [UW-1:0]           start_q;
	logic [NW-1:0]           run_q;
	logic [NW-1:0]           need_q;
	logic [NW-1:0]           cnt_q;
	logic                    first_q;
	logic                    fresh_q;
	logic [63:0]             word_q;
	logic [31:0]             frag_q;
	logic [1:0]              res_status_q;
	logic [15:0]             res_offset_q;
	logic                    m_tvalid_q;
	logic [1:0]              out_status_q;
	logic [15:0]             out_offset_q;
	logic [31:0]             out_frag_q;

	logic                    cmd_in;
	logic [16:0]             size_in;
	logic [15:0]             off_in;
	logic [31:0]             off_wide;
	logic [UW-1:0]           in_unit;
	logic                    free_bad;
	logic [NW-1:0]           need_in;
	logic [4:0]              pad;
	logic [32:0]             frag_sum;
	logic [31:0]             frag_new;

	logic [63:0]             ram_rdata;
	logic [63:0]             wsrc;
	logic [63:0]             word_next;
	logic [1:0]              chunk_sel;
	logic [5:0]              chunk_base;
	bffa_pkg::chunk_res_t    res;
	logic                    scan_hit;
	logic [UW-1:0]           end_unit;
	logic [31:0]             start_wide;
	logic [UW-1:0]           start_calc;
	logic [31:0]             start_bytes;
	logic [UW-4:0]           nb_hi;
	logic                    last_chunk;
	logic                    last_word;
	logic                    wb;
	logic                    ram_we;
	logic [WW-1:0]           ram_waddr;
	logic [63:0]             ram_wdata;
	logic [WW-1:0]           rd_addr;

	// initial contents of one bitmap word
	function automatic logic [63:0] reset_word(input logic [WW-1:0] w);
		logic [63:0] v;
		logic [31:0] u;
		v = '1;
		u = '0;
		for (int i = 0; i < 32; i++) begin
			u = 32'({w, 5'(i)});
			if (u < 32'(MAP_UNITS)) begin
				v[62-2*i +: 2] = (u == 32'd0) ? bffa_pkg::PAIR_START : bffa_pkg::PAIR_CONT;
			end else if (u < 32'(MAP_UNITS + RES_UNITS)) begin
				v[62-2*i +: 2] = (u == 32'(MAP_UNITS)) ? bffa_pkg::PAIR_START
				                                       : bffa_pkg::PAIR_CONT;
			end
		end
		return v;
	endfunction

	// input beat fields
	assign cmd_in  = s_tuser;
	assign size_in = s_tdata[16:0];
	assign off_in  = s_tdata[32:17];

	// free request decode
	assign off_wide = 32'(off_in) >> 4;
	assign in_unit  = off_wide[UW-1:0];
	assign free_bad = (off_in[3:0] != 4'd0) || (32'(off_in) >= (32'd1 << HEAP_LOG2));

	// allocate request decode and saturating padding total
	assign need_in  = NW'(size_in[16:4]) + NW'(size_in[3:0] != 4'd0);
	assign pad      = (size_in[3:0] != 4'd0) ? (5'd16 - 5'(size_in[3:0])) : 5'd0;
	assign frag_sum = {1'b0, frag_q} + 33'(pad);
	assign frag_new = frag_sum[32] ? 32'hFFFF_FFFF : frag_sum[31:0];

	// current word and chunk
	assign wsrc       = fresh_q ? ram_rdata : word_q;
	assign chunk_sel  = cur_q[4:3];
	assign chunk_base = 6'd48 - {chunk_sel, 4'b0000};
	assign last_chunk = &chunk_sel;
	assign last_word  = &cur_q[UW-1:5];
	assign nb_hi      = cur_q[UW-1:3] + (UW-3)'(1);

	bffa_chunk u_chunk (
		.mode     (mode_q),
		.pairs_in (wsrc[chunk_base +: 16]),
		.off      (cur_q[2:0]),
		.first    (first_q),
		.run_in   (run_q),
		.need     (need_q),
		.cnt_in   (cnt_q),
		.res      (res)
	);

	// merge the chunk back into the word
	always_comb begin
		word_next = wsrc;
		word_next[chunk_base +: 16] = res.pairs;
	end

	// run start from the unit where the scan hit
	assign scan_hit    = (mode_q == bffa_pkg::MODE_SCAN) && res.hit;
	assign end_unit    = {cur_q[UW-1:3], res.pos};
	assign start_wide  = 32'(end_unit) + 32'd1 - 32'(need_q);
	assign start_calc  = start_wide[UW-1:0];
	assign start_bytes = 32'(start_q) << 4;

	// bitmap write: clearing pass or word write-back
	assign wb        = (state_q == S_WORK) && (mode_q != bffa_pkg::MODE_SCAN) &&
	                   (res.hit || last_chunk);
	assign ram_we    = (state_q == S_CLEAR) || wb;
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : cur_q[UW-1:5];
	assign ram_wdata = (state_q == S_CLEAR) ? reset_word(clr_q) : word_next;

	// bitmap read: the word the next cycle works on
	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = (cmd_in == bffa_pkg::CMD_FREE) ? in_unit[UW-1:5] : '0;
			S_WORK:  rd_addr = scan_hit ? start_calc[UW-1:5] : nb_hi[UW-4:2];
			default: rd_addr = cur_q[UW-1:5];
		endcase
	end

	bffa_ram #(
		.WIDTH (64),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			mode_q       <= bffa_pkg::MODE_SCAN;
			clr_q        <= '0;
			cur_q        <= '0;
			start_q      <= '0;
			run_q        <= '0;
			need_q       <= '0;
			cnt_q        <= '0;
			first_q      <= 1'b0;
			fresh_q      <= 1'b0;
			word_q       <= '0;
			frag_q       <= '0;
			res_status_q <= bffa_pkg::ST_DONE;
			res_offset_q <= '0;
			m_tvalid_q   <= 1'b0;
			out_status_q <= bffa_pkg::ST_DONE;
			out_offset_q <= '0;
			out_frag_q   <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_RESP) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						res_offset_q <= '0;
						run_q        <= '0;
						first_q      <= 1'b1;
						fresh_q      <= 1'b1;
						if (cmd_in == bffa_pkg::CMD_ALLOC) begin
							if (size_in == 17'd0) begin
								res_status_q <= bffa_pkg::ST_REFUSED;
								state_q      <= S_RESP;
							end else begin
								frag_q  <= frag_new;
								need_q  <= need_in;
								cur_q   <= '0;
								mode_q  <= bffa_pkg::MODE_SCAN;
								state_q <= S_WORK;
							end
						end else begin
							if (free_bad) begin
								res_status_q <= bffa_pkg::ST_REFUSED;
								state_q      <= S_RESP;
							end else begin
								cur_q   <= in_unit;
								mode_q  <= bffa_pkg::MODE_FREE;
								state_q <= S_WORK;
							end
						end
					end
				end
				S_WORK: begin
					word_q  <= word_next;
					run_q   <= res.run;
					first_q <= scan_hit;
					fresh_q <= scan_hit || last_chunk;
					cnt_q   <= scan_hit ? need_q : res.cnt;
					cur_q   <= scan_hit ? start_calc : {nb_hi, 3'b000};
					case (mode_q)
						bffa_pkg::MODE_SCAN: begin
							if (res.hit) begin
								start_q <= start_calc;
								mode_q  <= bffa_pkg::MODE_MARK;
							end else if (last_chunk && last_word) begin
								res_status_q <= bffa_pkg::ST_NOFIT;
								state_q      <= S_RESP;
							end
						end
						bffa_pkg::MODE_MARK: begin
							if (res.hit) begin
								res_status_q <= bffa_pkg::ST_DONE;
								res_offset_q <= start_bytes[15:0];
								state_q      <= S_RESP;
							end
						end
						bffa_pkg::MODE_FREE: begin
							if (res.hit || (last_chunk && last_word)) begin
								res_status_q <= bffa_pkg::ST_DONE;
								state_q      <= S_RESP;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= res_status_q;
						out_offset_q <= res_offset_q;
						out_frag_q   <= frag_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ports
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, out_frag_q, out_offset_q, out_status_q};

	// a scan only reads the bitmap
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WORK && mode_q == bffa_pkg::MODE_SCAN) |-> !ram_we)
		else $error("bitmap written during scan");

	// marking always has units left to mark
	a_mark_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WORK && mode_q == bffa_pkg::MODE_MARK) |-> (cnt_q != '0))
		else $error("mark with empty count");

	// a result only appears out of the response state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_RESP))
		else $error("result without response state");

	// fragmentation total never goes down
	a_frag_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		frag_q >= $past(frag_q))
		else $error("fragmentation total decreased");

	// failed or refused requests carry no offset
	a_fail_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_status_q != bffa_pkg::ST_DONE) |-> (out_offset_q == 16'd0))
		else $error("offset on failed request");

endmodule
